[hw/rtl/fbpa_pkg.sv]
`default_nettype none
package fbpa_pkg;

  localparam int unsigned ADDR_W = 32;
  localparam int unsigned SIZE_W = 16;
  localparam int unsigned CNT_W  = 9;
  localparam int unsigned SPAN_W = CNT_W + SIZE_W;
  localparam int unsigned CMD_W  = 2;
  localparam int unsigned REGI_W = 2;

  typedef enum logic [CMD_W-1:0] {
    CMD_RESTART = 2'd0,
    CMD_ALLOC   = 2'd1,
    CMD_FREE    = 2'd2
  } cmd_t;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_EMPTY = 2'd1,
    STAT_RANGE = 2'd2,
    STAT_NONE  = 2'd3
  } status_t;

  typedef enum logic [REGI_W-1:0] {
    REG_BASE  = 2'd0,
    REG_SIZE  = 2'd1,
    REG_COUNT = 2'd2
  } reg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_READ = 3'b010,
    ST_FILL = 3'b100
  } state_t;

  typedef struct packed {
    status_t             status;
    logic [ADDR_W-1:0]   block_address;
    logic [CNT_W-1:0]    free_count;
  } res_t;

  typedef struct packed {
    logic             busy;
    logic [CNT_W-1:0] free_blocks;
    logic [CNT_W-1:0] outstanding;
  } ctrl_stat_t;

endpackage
`default_nettype wire

[hw/rtl/fbpa_ram.sv]
`default_nettype none
module fbpa_ram #(
  parameter int unsigned DEPTH = 256,
  parameter int unsigned WIDTH = 32,
  parameter int unsigned AW    = 8
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

[hw/rtl/fbpa_outq.sv]
`default_nettype none
module fbpa_outq
  import fbpa_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  push,
  input  res_t       push_data,
  output logic       room,
  output logic       out_valid,
  input  wire logic  out_ready,
  output res_t       head
);

  logic v0, v1;
  res_t d0, d1;
  logic pop;

  assign pop       = v0 && out_ready;
  assign room      = !v1;
  assign out_valid = v0;
  assign head      = d0;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
      v1 <= 1'b0;
    end else if (pop) begin
      if (v1) begin
        v1 <= push;
      end else begin
        v0 <= push;
      end
    end else if (!v0) begin
      v0 <= push;
    end else if (push) begin
      v1 <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      if (v1) begin
        d0 <= d1;
        d1 <= push_data;
      end else begin
        d0 <= push_data;
      end
    end else if (!v0) begin
      d0 <= push_data;
    end else if (push) begin
      d1 <= push_data;
    end
  end

endmodule
`default_nettype wire

[hw/rtl/fbpa_ctrl.sv]
`default_nettype none
module fbpa_ctrl
  import fbpa_pkg::*;
#(
  parameter int unsigned DEPTH = 256,
  parameter int unsigned PTR_W = 8
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic [ADDR_W-1:0] base_address,
  input  wire logic [SIZE_W-1:0] slot_size,
  input  wire logic [CNT_W-1:0]  slot_count,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [CMD_W-1:0]  command,
  input  wire logic [ADDR_W-1:0] address,
  input  wire logic              room,
  output logic                   res_valid,
  output res_t                   res,
  output logic                   mem_we,
  output logic [PTR_W-1:0]       mem_waddr,
  output logic [ADDR_W-1:0]      mem_wdata,
  output logic                   mem_re,
  output logic [PTR_W-1:0]       mem_raddr,
  input  wire logic [ADDR_W-1:0] mem_rdata,
  output ctrl_stat_t             stat
);

  // a count register can never exceed its own range, so the clamp stops there
  localparam int unsigned CNT_MAX   = (2 ** CNT_W) - 1;
  localparam int unsigned DEPTH_CAP = (DEPTH < CNT_MAX) ? DEPTH : CNT_MAX;
  localparam logic        CAP_WRAPS = (DEPTH <= CNT_MAX);

  state_t            state, state_next;
  logic [PTR_W-1:0]  rd_ptr, wr_ptr;
  logic [CNT_W-1:0]  free_blocks, outstanding;
  logic [ADDR_W-1:0] pool_start;
  logic [SPAN_W-1:0] span;
  logic [CNT_W-1:0]  fill_n, fill_idx;
  logic [ADDR_W-1:0] fill_addr;

  logic              accept;
  logic [CNT_W-1:0]  n_clamp;
  logic [ADDR_W-1:0] offs;
  logic              in_pool;
  logic              fill_done;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    ptr_inc = (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  assign in_ready  = (state == ST_IDLE) && room;
  assign accept    = in_valid && in_ready;
  assign n_clamp   = (slot_count > CNT_W'(DEPTH_CAP)) ? CNT_W'(DEPTH_CAP) : slot_count;
  assign offs      = address - pool_start;
  assign in_pool   = (address >= pool_start) && (offs < ADDR_W'(span));
  assign fill_done = (fill_idx == fill_n);

  assign stat.busy        = (state != ST_IDLE);
  assign stat.free_blocks = free_blocks;
  assign stat.outstanding = outstanding;

  always_comb begin
    state_next        = state;
    res_valid         = 1'b0;
    res.status        = STAT_OK;
    res.block_address = '0;
    res.free_count    = free_blocks;
    mem_we            = 1'b0;
    mem_waddr         = wr_ptr;
    mem_wdata         = address;
    mem_re            = 1'b0;
    mem_raddr         = rd_ptr;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          case (command)
            CMD_RESTART: state_next = ST_FILL;
            CMD_ALLOC: begin
              if (free_blocks == '0) begin
                res_valid  = 1'b1;
                res.status = STAT_EMPTY;
              end else begin
                mem_re     = 1'b1;
                state_next = ST_READ;
              end
            end
            CMD_FREE: begin
              res_valid = 1'b1;
              if (!in_pool) begin
                res.status = STAT_RANGE;
              end else if (outstanding == '0) begin
                res.status = STAT_NONE;
              end else begin
                mem_we         = 1'b1;
                res.free_count = free_blocks + CNT_W'(1);
              end
            end
            default: res_valid = 1'b1;
          endcase
        end
      end
      ST_READ: begin
        // room was checked at the transfer and only this path fills the queue
        res_valid         = 1'b1;
        res.block_address = mem_rdata;
        state_next        = ST_IDLE;
      end
      ST_FILL: begin
        if (fill_done) begin
          res_valid  = 1'b1;
          state_next = ST_IDLE;
        end else begin
          mem_we    = 1'b1;
          mem_waddr = PTR_W'(fill_idx);
          mem_wdata = fill_addr;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      rd_ptr      <= '0;
      wr_ptr      <= '0;
      free_blocks <= '0;
      outstanding <= '0;
      pool_start  <= '0;
      span        <= '0;
      fill_n      <= '0;
      fill_idx    <= '0;
    end else begin
      state <= state_next;
      if (accept) begin
        case (command)
          CMD_RESTART: begin
            pool_start  <= base_address;
            span        <= SPAN_W'(n_clamp) * SPAN_W'(slot_size);
            rd_ptr      <= '0;
            wr_ptr      <= (CAP_WRAPS && n_clamp == CNT_W'(DEPTH_CAP)) ? '0 : PTR_W'(n_clamp);
            free_blocks <= n_clamp;
            outstanding <= '0;
            fill_n      <= n_clamp;
            fill_idx    <= '0;
          end
          CMD_ALLOC: begin
            if (free_blocks != '0) begin
              rd_ptr      <= ptr_inc(rd_ptr);
              free_blocks <= free_blocks - CNT_W'(1);
              outstanding <= outstanding + CNT_W'(1);
            end
          end
          CMD_FREE: begin
            if (in_pool && outstanding != '0) begin
              wr_ptr      <= ptr_inc(wr_ptr);
              free_blocks <= free_blocks + CNT_W'(1);
              outstanding <= outstanding - CNT_W'(1);
            end
          end
          default: ;
        endcase
      end else if (state == ST_FILL && !fill_done) begin
        fill_idx <= fill_idx + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      fill_addr <= base_address;
    end else if (state == ST_FILL) begin
      fill_addr <= fill_addr + ADDR_W'(slot_size);
    end
  end

endmodule
`default_nettype wire

[hw/rtl/fixed_block_pool_allocator_top.sv]
// Fixed-size block pool with a FIFO free list held in a single-port-write,
// registered-read memory.
// Channels: in (command, address) and out (status, block_address,
// free_count) use valid/ready; cfg (cfg_index, cfg_data) writes
// base_address, slot_size or slot_count and is always ready. Config is
// only to be changed by the user while the block is idle; the block does
// not enforce this. Config takes effect at the next restart. Per item:
//   free, unknown command, allocate on an empty pool: result queued in
//   the transfer cycle, next item accepted on the following edge
//   allocate: free-list memory read in the READ state, then result queued
//   restart: n = min(slot_count, DEPTH), FILL does one memory write a
//   cycle while the list is refilled, then the result is queued
// Results go into a two-entry output queue, so an item is accepted while
// a result still waits; when the receiver stalls and both entries are
// full, in_ready drops until a transfer on out frees one.
// Reset clears the pointers and counters: the pool reads as empty until
// the first restart. Config registers reset to base 0, size 64, count 256.
`default_nettype none
module fixed_block_pool_allocator_top
  import fbpa_pkg::*;
#(
  parameter int unsigned DEPTH = 256
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              cfg_valid,
  output logic                   cfg_ready,
  input  wire logic [REGI_W-1:0] cfg_index,
  input  wire logic [31:0]       cfg_data,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [CMD_W-1:0]  command,
  input  wire logic [ADDR_W-1:0] address,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic [1:0]             status,
  output logic [ADDR_W-1:0]      block_address,
  output logic [CNT_W-1:0]       free_count
);

  localparam int unsigned PTR_W    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_MAX  = (2 ** CNT_W) - 1;
  localparam int unsigned POOL_CAP = (DEPTH < CNT_MAX) ? DEPTH : CNT_MAX;

  logic [ADDR_W-1:0] base_address;
  logic [SIZE_W-1:0] slot_size;
  logic [CNT_W-1:0]  slot_count;

  logic              room, res_valid;
  res_t              res, head;
  logic              mem_we, mem_re;
  logic [PTR_W-1:0]  mem_waddr, mem_raddr;
  logic [ADDR_W-1:0] mem_wdata, mem_rdata;
  ctrl_stat_t        stat;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      base_address <= '0;
      slot_size    <= SIZE_W'(64);
      slot_count   <= CNT_W'(256);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_BASE:  base_address <= cfg_data[ADDR_W-1:0];
        REG_SIZE:  slot_size    <= cfg_data[SIZE_W-1:0];
        REG_COUNT: slot_count   <= cfg_data[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  fbpa_ctrl #(
    .DEPTH (DEPTH),
    .PTR_W (PTR_W)
  ) u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .base_address (base_address),
    .slot_size    (slot_size),
    .slot_count   (slot_count),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .command      (command),
    .address      (address),
    .room         (room),
    .res_valid    (res_valid),
    .res          (res),
    .mem_we       (mem_we),
    .mem_waddr    (mem_waddr),
    .mem_wdata    (mem_wdata),
    .mem_re       (mem_re),
    .mem_raddr    (mem_raddr),
    .mem_rdata    (mem_rdata),
    .stat         (stat)
  );

  fbpa_ram #(
    .DEPTH (DEPTH),
    .WIDTH (ADDR_W),
    .AW    (PTR_W)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  fbpa_outq u_outq (
    .clk       (clk),
    .rst       (rst),
    .push      (res_valid),
    .push_data (res),
    .room      (room),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .head      (head)
  );

  assign status        = head.status;
  assign block_address = head.block_address;
  assign free_count    = head.free_count;

  // blocks handed out plus blocks on the list never exceed the pool
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    ({1'b0, stat.free_blocks} + {1'b0, stat.outstanding}) <= (CNT_W + 1)'(POOL_CAP))
    else $error("free plus outstanding exceeds pool size");

  // a result is only produced when the output queue can take it
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> room)
    else $error("result pushed into a full output queue");

  // no new item while a read or refill is in flight
  a_busy_blocks: assert property (@(posedge clk) disable iff (rst)
    stat.busy |-> !in_ready)
    else $error("input ready while busy");

  // memory is never read and written in the same cycle
  a_mem_excl: assert property (@(posedge clk) disable iff (rst)
    !(mem_we && mem_re))
    else $error("overlapping memory read and write");

endmodule
`default_nettype wire
